// ----- sv/bbcc_pkg.sv -----
package bbcc_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        CMD_INODE = 2'd0,
        CMD_BLOCK = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // pointer fault codes
    localparam logic [1:0] PTR_OK    = 2'd0;
    localparam logic [1:0] PTR_RANGE = 2'd1;
    localparam logic [1:0] PTR_DUP   = 2'd2;

    // bitmap bit fault codes
    localparam logic [1:0] BIT_OK      = 2'd0;
    localparam logic [1:0] BIT_EXTRA   = 2'd1;
    localparam logic [1:0] BIT_MISSING = 2'd2;

    localparam logic CFG_FIRST_DATA = 1'b0;
    localparam logic CFG_TOTAL      = 1'b1;

    localparam logic [5:0] FIRST_DATA_RST = 6'd8;
    localparam logic [6:0] TOTAL_RST      = 7'd64;

    typedef struct packed {
        logic        data_marked;
        logic [5:0]  block_number;
        logic [31:0] indirect_pointer;
        logic [31:0] direct_pointer;
        logic        inode_marked;
        logic [31:0] delete_time;
        logic [15:0] link_count;
    } in_data_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] error_total;
        logic [1:0]  data_fault;
        logic        data_bit_fixed;
        logic [1:0]  indirect_fault;
        logic [31:0] indirect_fixed;
        logic [1:0]  direct_fault;
        logic [31:0] direct_fixed;
        logic [1:0]  inode_fault;
        logic        inode_bit_fixed;
        logic        inode_ok;
    } out_data_t;

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
    } map_req_t;

    function automatic logic in_range(logic [31:0] b, logic [5:0] first, logic [6:0] total);
        return (b >= {26'd0, first}) && (b < {25'd0, total}) && (b < 32'(MAX_BLOCKS));
    endfunction

endpackage

// ----- sv/bbcc_map.sv -----
module bbcc_map (
    input  logic               clk,
    input  logic               rst_n,
    input  bbcc_pkg::map_req_t req,
    input  logic               clear_start,
    output logic               busy,
    output logic               hit
);
    import bbcc_pkg::*;

    logic  mem [MAX_BLOCKS];
    logic  rd_q_reg;
    logic  fwd_reg;
    logic  busy_reg;
    addr_t clr_addr_reg;

    // mark or sweep, read old contents
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= 1'b1;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (req.rd_en)
            begin
                fwd_reg <= req.wr_en && !busy_reg && (req.wr_addr == req.rd_addr);
            end
            if (clear_start)
            begin
                busy_reg     <= 1'b1;
                clr_addr_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (clr_addr_reg == addr_t'(MAX_BLOCKS - 1))
                begin
                    busy_reg     <= 1'b0;
                    clr_addr_reg <= '0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + addr_t'(1);
                end
            end
        end
    end

    assign busy = busy_reg;
    assign hit  = rd_q_reg | fwd_reg;

endmodule

// ----- sv/block_bitmap_consistency_checker_unit.sv -----
// A result is registered onto m_axis after the direct (ST_DIR) and indirect (ST_IND)
// stages; ST_IND holds while the output is full. A new request can be taken in the
// same cycle as the previous result is registered; two dependent read-modify-writes
// of the block map (direct, then indirect pointer) set the pace. A start request is
// followed by a map sweep clearing every entry, no request taken. Reset: asynchronous,
// active low; clears counter and control, loads data range bounds 8 and 64, sweeps the map.
module block_bitmap_consistency_checker_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [6:0]            cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // link_count, delete_time, inode_marked, direct_pointer, indirect_pointer,
    // block_number, data_marked
    input  bbcc_pkg::in_data_t    s_axis_tdata,
    // command
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // inode_ok, inode_bit_fixed, inode_fault, direct_fixed, direct_fault,
    // indirect_fixed, indirect_fault, data_bit_fixed, data_fault, error_total, zero pad
    output bbcc_pkg::out_data_t   m_axis_tdata
);
    import bbcc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIR  = 3'b010,
        ST_IND  = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  first_reg;
    logic [6:0]  total_reg;
    logic [15:0] err_cnt_reg;
    logic [15:0] err_cnt_next;
    logic        out_valid_reg;
    out_data_t   out_reg;
    out_data_t   out_next;

    cmd_t        cmd_reg;
    logic        valid_reg;
    logic        imark_reg;
    logic [31:0] dptr_reg;
    logic [31:0] iptr_reg;
    logic        d_inr_reg;
    logic        i_inr_reg;
    logic        b_inr_reg;
    logic        dmark_reg;
    logic [31:0] dfix_reg, dfix_next;
    logic [1:0]  dflt_reg, dflt_next;
    logic        dbit_reg, dbit_next;
    logic [1:0]  dbflt_reg, dbflt_next;

    map_req_t    map_req;
    logic        map_busy;
    logic        map_hit;
    logic        clear_start;

    cmd_t        in_cmd;
    logic        accept;
    logic        out_free;
    logic        fire;
    logic        is_inode;
    logic        mark_d;
    logic        mark_i;
    logic [1:0]  iflt;
    logic [1:0]  inflt;
    logic [31:0] ifix;
    logic [1:0]  n_faults;
    logic [16:0] cnt_sum;

    bbcc_map u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (map_req),
        .clear_start (clear_start),
        .busy        (map_busy),
        .hit         (map_hit)
    );

    assign in_cmd   = cmd_t'(s_axis_tuser);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign fire     = (state_reg == ST_IND) && out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_inode = (cmd_reg == CMD_INODE) && valid_reg;

    assign s_axis_tready = !map_busy &&
                           ((state_reg == ST_IDLE) || (fire && (cmd_reg != CMD_START)));

    assign mark_d = is_inode && (dptr_reg != 32'd0) && d_inr_reg && !map_hit;
    assign mark_i = is_inode && (iptr_reg != 32'd0) && i_inr_reg && !map_hit;

    always_comb
    begin
        map_req.rd_en = accept || (state_reg == ST_DIR);
        if (state_reg == ST_DIR)
        begin
            map_req.rd_addr = addr_t'(iptr_reg);
        end
        else if (in_cmd == CMD_BLOCK)
        begin
            map_req.rd_addr = addr_t'(s_axis_tdata.block_number);
        end
        else
        begin
            map_req.rd_addr = addr_t'(s_axis_tdata.direct_pointer);
        end
        map_req.wr_en   = ((state_reg == ST_DIR) && mark_d) || (fire && mark_i);
        map_req.wr_addr = (state_reg == ST_DIR) ? addr_t'(dptr_reg) : addr_t'(iptr_reg);
    end

    // direct pointer and data bit, read issued at accept
    always_comb
    begin
        dflt_next = PTR_OK;
        if (is_inode && (dptr_reg != 32'd0))
        begin
            if (!d_inr_reg)
            begin
                dflt_next = PTR_RANGE;
            end
            else if (map_hit)
            begin
                dflt_next = PTR_DUP;
            end
        end
        if (cmd_reg != CMD_INODE)
        begin
            dfix_next = 32'd0;
        end
        else
        begin
            dfix_next = (dflt_next != PTR_OK) ? 32'd0 : dptr_reg;
        end
        dbit_next  = 1'b0;
        dbflt_next = BIT_OK;
        if (cmd_reg == CMD_BLOCK)
        begin
            dbit_next = b_inr_reg ? map_hit : dmark_reg;
            if (b_inr_reg && dmark_reg && !map_hit)
            begin
                dbflt_next = BIT_EXTRA;
            end
            else if (b_inr_reg && !dmark_reg && map_hit)
            begin
                dbflt_next = BIT_MISSING;
            end
        end
    end

    // indirect pointer, inode bit, counter and result
    always_comb
    begin
        iflt = PTR_OK;
        if (is_inode && (iptr_reg != 32'd0))
        begin
            if (!i_inr_reg)
            begin
                iflt = PTR_RANGE;
            end
            else if (map_hit)
            begin
                iflt = PTR_DUP;
            end
        end
        if (cmd_reg != CMD_INODE)
        begin
            ifix = 32'd0;
        end
        else
        begin
            ifix = (iflt != PTR_OK) ? 32'd0 : iptr_reg;
        end
        inflt = BIT_OK;
        if (cmd_reg == CMD_INODE)
        begin
            if (imark_reg && !valid_reg)
            begin
                inflt = BIT_EXTRA;
            end
            else if (!imark_reg && valid_reg)
            begin
                inflt = BIT_MISSING;
            end
        end
        n_faults = 2'(inflt != BIT_OK) + 2'(dflt_reg != PTR_OK) + 2'(iflt != PTR_OK)
                 + 2'(dbflt_reg != BIT_OK);
        cnt_sum  = {1'b0, err_cnt_reg} + 17'(n_faults);
        if (cmd_reg == CMD_START)
        begin
            err_cnt_next = 16'd0;
        end
        else
        begin
            err_cnt_next = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
        end

        out_next.pad             = '0;
        out_next.error_total     = err_cnt_next;
        out_next.data_fault      = dbflt_reg;
        out_next.data_bit_fixed  = dbit_reg;
        out_next.indirect_fault  = iflt;
        out_next.indirect_fixed  = ifix;
        out_next.direct_fault    = dflt_reg;
        out_next.direct_fixed    = dfix_reg;
        out_next.inode_fault     = inflt;
        out_next.inode_bit_fixed = is_inode;
        out_next.inode_ok        = is_inode;
    end

    assign clear_start = fire && (cmd_reg == CMD_START);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIR;
                end
            end
            ST_DIR:
            begin
                state_next = ST_IND;
            end
            ST_IND:
            begin
                if (fire)
                begin
                    state_next = accept ? ST_DIR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= FIRST_DATA_RST;
            total_reg     <= TOTAL_RST;
            err_cnt_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_addr == CFG_FIRST_DATA)
                begin
                    first_reg <= cfg_wdata[5:0];
                end
                else
                begin
                    total_reg <= cfg_wdata;
                end
            end
            if (fire)
            begin
                err_cnt_reg   <= err_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold request fields and stage results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_cmd;
            valid_reg <= (s_axis_tdata.link_count != 16'd0) &&
                         (s_axis_tdata.delete_time == 32'd0);
            imark_reg <= s_axis_tdata.inode_marked;
            dptr_reg  <= s_axis_tdata.direct_pointer;
            iptr_reg  <= s_axis_tdata.indirect_pointer;
            d_inr_reg <= in_range(s_axis_tdata.direct_pointer, first_reg, total_reg);
            i_inr_reg <= in_range(s_axis_tdata.indirect_pointer, first_reg, total_reg);
            b_inr_reg <= in_range({26'd0, s_axis_tdata.block_number}, first_reg, total_reg);
            dmark_reg <= s_axis_tdata.data_marked;
        end
        if (state_reg == ST_DIR)
        begin
            dfix_reg  <= dfix_next;
            dflt_reg  <= dflt_next;
            dbit_reg  <= dbit_next;
            dbflt_reg <= dbflt_next;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    a_dir_to_ind: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIR |=> state_reg == ST_IND)
        else $error("direct stage did not advance");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IND && !out_free) |=> (state_reg == ST_IND && $stable(err_cnt_reg)))
        else $error("result stage moved while output full");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg == CMD_START) |=> (err_cnt_reg == 16'd0 && map_busy))
        else $error("start did not clear counter and map");

    a_no_mark_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        map_busy |-> !map_req.wr_en)
        else $error("map mark during sweep");

endmodule

// ----- tb/tb_block_bitmap_consistency_checker_unit.sv -----
module tb_block_bitmap_consistency_checker_unit;
    import bbcc_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_WAIT = MAX_BLOCKS + 8;
    localparam int NUM_PHASES  = 9;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_addr;
    logic [6:0] cfg_wdata;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    in_data_t   s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    out_data_t  m_axis_tdata;

    // predictor state
    logic [MAX_BLOCKS-1:0] blocks_referenced = '0;
    logic [15:0]           fault_tally       = '0;
    logic [5:0]            window_lo         = FIRST_DATA_RST;
    logic [6:0]            window_end        = TOTAL_RST;

    out_data_t pending_verdicts[$];
    out_data_t head_verdict;

    int  mismatches     = 0;
    int  requests_sent  = 0;
    int  results_seen   = 0;
    int  settings_used  = 1;
    int  idle_cycles    = 0;
    int  quiet_items    = 0;
    bit  no_stall       = 1'b0;

    block_bitmap_consistency_checker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic bit block_in_window(logic [31:0] b);
        return (b >= {26'd0, window_lo}) && (b < {25'd0, window_end}) && (b < MAX_BLOCKS);
    endfunction

    function automatic void bump_faults();
        if (fault_tally != 16'hFFFF)
            fault_tally = fault_tally + 16'd1;
    endfunction

    function automatic void screen_pointer(input logic [31:0] p, output logic [31:0] fixed,
                                           output logic [1:0] fault);
        fixed = p;
        fault = PTR_OK;
        if (p == 0)
            return;
        if (!block_in_window(p))
        begin
            fixed = '0;
            fault = PTR_RANGE;
            bump_faults();
        end
        else if (blocks_referenced[p[ADDR_W-1:0]])
        begin
            fixed = '0;
            fault = PTR_DUP;
            bump_faults();
        end
        else
            blocks_referenced[p[ADDR_W-1:0]] = 1'b1;
    endfunction

    function automatic out_data_t predict_result(logic [1:0] cmd, in_data_t d);
        out_data_t r;
        logic      live;
        logic      used;
        r = '0;
        case (cmd)
            CMD_START:
            begin
                blocks_referenced = '0;
                fault_tally = '0;
            end
            CMD_INODE:
            begin
                live = (d.link_count != 0) && (d.delete_time == 0);
                r.inode_ok = live;
                r.inode_bit_fixed = live;
                if (d.inode_marked && !live)
                begin
                    r.inode_fault = BIT_EXTRA;
                    bump_faults();
                end
                else if (!d.inode_marked && live)
                begin
                    r.inode_fault = BIT_MISSING;
                    bump_faults();
                end
                if (live)
                begin
                    screen_pointer(d.direct_pointer, r.direct_fixed, r.direct_fault);
                    screen_pointer(d.indirect_pointer, r.indirect_fixed, r.indirect_fault);
                end
                else
                begin
                    r.direct_fixed = d.direct_pointer;
                    r.indirect_fixed = d.indirect_pointer;
                end
            end
            CMD_BLOCK:
            begin
                r.data_bit_fixed = d.data_marked;
                if (block_in_window({26'd0, d.block_number}))
                begin
                    used = blocks_referenced[d.block_number];
                    r.data_bit_fixed = used;
                    if (d.data_marked && !used)
                    begin
                        r.data_fault = BIT_EXTRA;
                        bump_faults();
                    end
                    else if (!d.data_marked && used)
                    begin
                        r.data_fault = BIT_MISSING;
                        bump_faults();
                    end
                end
            end
            default: ;
        endcase
        r.error_total = fault_tally;
        return r;
    endfunction

    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (no_stall)
            return 0;
        if (quiet_items > 0)
        begin
            quiet_items--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            quiet_items = 40;
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return draw_pause();
    endfunction

    function automatic in_data_t noise_fields();
        in_data_t d;
        d.link_count       = 16'($urandom);
        d.delete_time      = $urandom;
        d.inode_marked     = 1'($urandom);
        d.direct_pointer   = $urandom;
        d.indirect_pointer = $urandom;
        d.block_number     = 6'($urandom);
        d.data_marked      = 1'($urandom);
        return d;
    endfunction

    function automatic in_data_t inode_fields(logic [15:0] links, logic [31:0] dtime,
                                              logic marked, logic [31:0] dptr,
                                              logic [31:0] iptr);
        in_data_t d;
        d = noise_fields();
        d.link_count       = links;
        d.delete_time      = dtime;
        d.inode_marked     = marked;
        d.direct_pointer   = dptr;
        d.indirect_pointer = iptr;
        return d;
    endfunction

    function automatic in_data_t block_fields(logic [5:0] blk, logic marked);
        in_data_t d;
        d = noise_fields();
        d.block_number = blk;
        d.data_marked  = marked;
        return d;
    endfunction

    task automatic send_request(logic [1:0] cmd, in_data_t d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_verdicts.push_back(predict_result(cmd, d));
        requests_sent++;
    endtask

    // hold the sender until every pending result is out
    task automatic drain(int extra);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_limits(logic [5:0] lo, logic [6:0] bound);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_FIRST_DATA;
        cfg_wdata <= {1'($urandom), lo};
        @(posedge clk);
        window_lo  = lo;
        cfg_addr  <= CFG_TOTAL;
        cfg_wdata <= bound;
        @(posedge clk);
        window_end = bound;
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [31:0] pick_block_number();
        int r;
        int hi;
        hi = (window_end > MAX_BLOCKS) ? MAX_BLOCKS - 1 : int'(window_end) - 1;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 65 && hi >= int'(window_lo))
            return $urandom_range(int'(window_lo), hi);
        if (r < 80)
            return $urandom_range(0, MAX_BLOCKS - 1);
        if (r < 90)
        begin
            case ($urandom_range(0, 4))
                0: return {26'd0, window_lo} - 32'd1;
                1: return {26'd0, window_lo};
                2: return {25'd0, window_end} - 32'd1;
                3: return {25'd0, window_end};
                default: return MAX_BLOCKS;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_random_item();
        int         r;
        logic [15:0] links;
        logic [31:0] dtime;
        logic        live;
        logic        marked;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            case ($urandom_range(0, 6))
                0:       links = 16'd0;
                1:       links = 16'hFFFF;
                default: links = 16'($urandom_range(1, 16'hFFFF));
            endcase
            dtime = ($urandom_range(0, 4) == 0) ? $urandom : 32'd0;
            live = (links != 0) && (dtime == 0);
            marked = ($urandom_range(0, 3) == 0) ? !live : live;
            send_request(CMD_INODE, inode_fields(links, dtime, marked,
                         pick_block_number(), pick_block_number()));
        end
        else if (r < 88)
        begin
            marked = ($urandom_range(0, 3) == 0) ? 1'($urandom) : 1'b1;
            send_request(CMD_BLOCK, block_fields(6'(pick_block_number()), marked));
        end
        else if (r < 94)
            send_request(CMD_START, noise_fields());
        else if (r < 97)
            send_request(CMD_NONE, noise_fields());
        else
            send_request(CMD_INODE, noise_fields());
    endtask

    task automatic test_inode_checks();
        send_request(CMD_START, noise_fields());
        send_request(CMD_INODE, inode_fields(16'd1, 32'd0, 1'b0, 32'd8, 32'd8));
        send_request(CMD_INODE, inode_fields(16'hFFFF, 32'd0, 1'b1, 32'd63, 32'd0));
        send_request(CMD_INODE, inode_fields(16'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'h12345));
        send_request(CMD_INODE, inode_fields(16'd5, 32'hFFFF_FFFF, 1'b0, 32'd9, 32'd10));
        send_request(CMD_INODE, inode_fields(16'd2, 32'd0, 1'b1, 32'd7, 32'd64));
        send_request(CMD_INODE, inode_fields(16'd3, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd63));
        send_request(CMD_INODE, inode_fields(16'd1, 32'd0, 1'b1, 32'd9, 32'd10));
        send_request(CMD_INODE, inode_fields(16'd1, 32'd0, 1'b0, 32'd0, 32'd0));
    endtask

    task automatic test_block_checks();
        send_request(CMD_BLOCK, block_fields(6'd8, 1'b1));
        send_request(CMD_BLOCK, block_fields(6'd63, 1'b0));
        send_request(CMD_BLOCK, block_fields(6'd11, 1'b1));
        send_request(CMD_BLOCK, block_fields(6'd12, 1'b0));
        send_request(CMD_BLOCK, block_fields(6'd0, 1'b1));
        send_request(CMD_BLOCK, block_fields(6'd7, 1'b0));
    endtask

    task automatic test_unused_command();
        send_request(CMD_NONE, noise_fields());
        send_request(CMD_START, noise_fields());
        send_request(CMD_BLOCK, block_fields(6'd8, 1'b1));
    endtask

    // three faults per request: unmarked live inode, two out-of-range pointers
    task automatic test_fault_burst();
        drain(2);
        no_stall = 1'b1;
        send_request(CMD_START, noise_fields());
        repeat (40)
            send_request(CMD_INODE, inode_fields(16'd1, 32'd0, 1'b0,
                                                 32'hFFFF_FFFF, 32'hFFFF_FFC0));
        send_request(CMD_BLOCK, block_fields(6'd20, 1'b1));
        no_stall = 1'b0;
        drain(2);
    endtask

    task automatic test_random_phases();
        logic [5:0] lo_set[NUM_PHASES]    = '{6'd8, 6'd0, 6'd1, 6'd63, 6'd0,
                                              6'd40, 6'd5, 6'd16, 6'd0};
        logic [6:0] bound_set[NUM_PHASES] = '{7'd64, 7'd64, 7'd127, 7'd64, 7'd1,
                                              7'd20, 7'd50, 7'd100, 7'd127};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain(SETTLE_WAIT);
            write_limits(lo_set[p], bound_set[p]);
            send_request(CMD_START, noise_fields());
            repeat (112)
                send_random_item();
        end
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result arrived with no request pending");
                mismatches++;
            end
            else
            begin
                head_verdict = pending_verdicts.pop_front();
                results_seen++;
                compare_field("inode_ok", 32'(head_verdict.inode_ok),
                              32'(m_axis_tdata.inode_ok));
                compare_field("inode_bit_fixed", 32'(head_verdict.inode_bit_fixed),
                              32'(m_axis_tdata.inode_bit_fixed));
                compare_field("inode_fault", 32'(head_verdict.inode_fault),
                              32'(m_axis_tdata.inode_fault));
                compare_field("direct_fixed", head_verdict.direct_fixed,
                              m_axis_tdata.direct_fixed);
                compare_field("direct_fault", 32'(head_verdict.direct_fault),
                              32'(m_axis_tdata.direct_fault));
                compare_field("indirect_fixed", head_verdict.indirect_fixed,
                              m_axis_tdata.indirect_fixed);
                compare_field("indirect_fault", 32'(head_verdict.indirect_fault),
                              32'(m_axis_tdata.indirect_fault));
                compare_field("data_bit_fixed", 32'(head_verdict.data_bit_fixed),
                              32'(m_axis_tdata.data_bit_fixed));
                compare_field("data_fault", 32'(head_verdict.data_fault),
                              32'(m_axis_tdata.data_fault));
                compare_field("error_total", 32'(head_verdict.error_total),
                              32'(m_axis_tdata.error_total));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (no_stall)
                m_axis_tready <= 1'b1;
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:2]:
                    begin
                        m_axis_tready <= 1'b1;
                        hold = 60;
                    end
                    [3:64]:
                    begin
                        m_axis_tready <= 1'b1;
                        hold = $urandom_range(0, 8);
                    end
                    default:
                    begin
                        m_axis_tready <= 1'b0;
                        hold = draw_pause() - 1;
                    end
                endcase
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_FIRST_DATA;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = CMD_NONE;
        s_axis_tdata  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_inode_checks();
        test_block_checks();
        test_unused_command();
        test_fault_burst();
        test_random_phases();

        drain(20);
        $display("Sent %0d requests and checked %0d results over %0d range settings,",
                 requests_sent, results_seen, settings_used);
        $display("including bursts of pointer faults and map clears by start requests.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- block_bitmap_consistency_checker_unit.f -----
sv/bbcc_pkg.sv
sv/bbcc_map.sv
sv/block_bitmap_consistency_checker_unit.sv
tb/tb_block_bitmap_consistency_checker_unit.sv
